// File: rtl/blocked_bloom_filter_macros.svh
// Assertion macros for the blocked Bloom filter.
// Used by the top level; no other dependencies.
`ifndef BLOCKED_BLOOM_FILTER_MACROS_SVH
`define BLOCKED_BLOOM_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define BBF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BBF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BBF_ASSERT_NOW(label, clk, rstn, ante, cons)
`define BBF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/bbf_pkg.sv
// Shared types and constants for the blocked Bloom filter.
// No dependencies.
`default_nettype none
package bbf_pkg;

    localparam int unsigned DIV_W = 32;

    // actions
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_PROBES = 2'd0;
    localparam logic [1:0] REG_BBYTES = 2'd1;
    localparam logic [1:0] REG_BLOCKS = 2'd2;

    // hash constants
    localparam logic [31:0] HASH_SEED = 32'd2568;
    localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2     = 32'h1b873593;
    localparam logic [31:0] MM_ADD    = 32'he6546b64;
    localparam logic [31:0] MM_F1     = 32'h85ebca6b;
    localparam logic [31:0] MM_F2     = 32'hc2b2ae35;
    localparam logic [31:0] MM_LEN    = 32'd8;
    localparam logic [31:0] MM_FIVE   = 32'd5;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } bbf_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } bbf_div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/bbf_div.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on bbf_pkg.
`default_nettype none
module bbf_div
    import bbf_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  bbf_div_req_t req,
    output bbf_div_rsp_t rsp
);
    localparam int unsigned CW = $clog2(DIV_W);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DIV_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

// File: rtl/blocked_bloom_filter.sv
// Blocked Bloom filter with one MurmurHash3 hash over a byte memory.
// Depends on bbf_pkg, bbf_div and blocked_bloom_filter_macros.svh.
// Use:
//   s_valid/s_ready carry a request (s_action, s_key): insert, look up or
//   clear. Every request gives one result on m_valid/m_ready (m_present).
//   cfg_valid/cfg_ready write probe_count (0), block_bytes (1) and
//   block_total (2); cfg_ready is always high, write only while idle.
// Steps (one request at a time):
//   hash on the shared multiplier; block pick by one remainder pass; base
//   multiply and reciprocal wrap into memory; each probe a remainder pass,
//   address, read and check; a lookup stops at the first clear bit. A clear
//   sweeps one byte a cycle.
// Reset:
//   registers return to 7/64/128 and the memory is swept to zero, while
//   s_ready stays low.
// Stall:
//   the result sits in an output register; a new request is taken while it
//   waits, and its result is held back until the old one has gone.
`default_nettype none
`include "blocked_bloom_filter_macros.svh"
module blocked_bloom_filter
    import bbf_pkg::*;
#(
    parameter int unsigned MEM_BYTES  = 8192,
    parameter int unsigned MAX_PROBES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [63:0] s_key,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_present,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_data
);
    localparam int unsigned AW = $clog2(MEM_BYTES);
    localparam int unsigned PW = $clog2(MAX_PROBES + 1);
    localparam logic [AW:0] MEM_SZ = (AW+1)'(MEM_BYTES);
    localparam logic [31:0] MEM_W = 32'(MEM_BYTES);
    // floor(2^32 / MEM_BYTES): quotient estimate is low by one at most
    localparam logic [31:0] MEM_RECIP = 32'(64'h1_0000_0000 / 64'(MEM_BYTES));

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_HASH  = 4'd2;
    localparam logic [3:0] ST_BDIV  = 4'd3;
    localparam logic [3:0] ST_BASE  = 4'd4;
    localparam logic [3:0] ST_MST   = 4'd5;
    localparam logic [3:0] ST_MDIV  = 4'd6;
    localparam logic [3:0] ST_PROBE = 4'd7;
    localparam logic [3:0] ST_PDIV  = 4'd8;
    localparam logic [3:0] ST_RD    = 4'd9;
    localparam logic [3:0] ST_CHK   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    // configuration
    logic [4:0]  probes_cfg_reg, probes_cfg_next;
    logic [6:0]  bbytes_cfg_reg, bbytes_cfg_next;
    logic [13:0] blocks_cfg_reg, blocks_cfg_next;

    // sequencer state
    logic [3:0]    state_reg, state_next;
    logic [3:0]    hstep_reg, hstep_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clr_reply_reg, clr_reply_next;
    logic          is_ins_reg, is_ins_next;
    logic [63:0]   key_reg, key_next;
    logic [31:0]   h_reg, h_next;
    logic [31:0]   t_reg, t_next;
    logic [31:0]   q_reg, q_next;
    logic [PW-1:0] probes_reg, probes_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [6:0]    bsize_reg, bsize_next;
    logic [13:0]   blocks_reg, blocks_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [2:0]    bit_reg, bit_next;
    logic          res_reg, res_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_present_reg, m_present_next;

    // memory
    logic [7:0]    mem [MEM_BYTES];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [7:0]    mem_wd;

    // shared multiplier, full product
    logic [31:0] mul_a, mul_b, mul_p;
    logic [63:0] mul_full;
    assign mul_full = 64'(mul_a) * 64'(mul_b);
    assign mul_p    = mul_full[31:0];

    bbf_div_req_t div_req;
    bbf_div_rsp_t div_rsp;

    bbf_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

    logic [31:0]   probe_val;
    logic [AW:0]   addr_sum;
    logic [7:0]    bit_mask;
    logic          out_free;
    logic [31:0]   wrap_diff;
    logic          div_wait;
    logic          out_take;

    assign probe_val = {16'd0, h_reg[31:16]} ^ (h_reg << idx_reg);
    assign addr_sum  = (AW+1)'(base_reg) + (AW+1)'(div_rsp.rem[9:3]);
    assign bit_mask  = 8'h80 >> bit_reg;
    assign out_free  = !m_valid_reg || m_ready;
    // base product less estimated multiple: below twice MEM_BYTES
    assign wrap_diff = t_reg - mul_p;
    assign div_wait  = (state_reg == ST_BDIV) || (state_reg == ST_PDIV);
    assign out_take  = (state_reg == ST_DONE) && out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_present = m_present_reg;

    always_comb begin
        probes_cfg_next = probes_cfg_reg;
        bbytes_cfg_next = bbytes_cfg_reg;
        blocks_cfg_next = blocks_cfg_reg;
        state_next      = state_reg;
        hstep_next      = hstep_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_reply_next  = clr_reply_reg;
        is_ins_next     = is_ins_reg;
        key_next        = key_reg;
        h_next          = h_reg;
        t_next          = t_reg;
        q_next          = q_reg;
        probes_next     = probes_reg;
        idx_next        = idx_reg;
        bsize_next      = bsize_reg;
        blocks_next     = blocks_reg;
        base_next       = base_reg;
        addr_next       = addr_reg;
        bit_next        = bit_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_present_next  = m_present_reg;
        mul_a           = '0;
        mul_b           = '0;
        div_req         = '0;
        mem_we          = 1'b0;
        mem_wd          = '0;
        mem_addr        = addr_reg;

        if (cfg_valid) begin
            case (cfg_index)
                REG_PROBES: probes_cfg_next = cfg_data[4:0];
                REG_BBYTES: bbytes_cfg_next = cfg_data[6:0];
                REG_BLOCKS: blocks_cfg_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next    = s_key;
                    is_ins_next = (s_action == ACT_INSERT);
                    h_next      = HASH_SEED;
                    hstep_next  = '0;
                    idx_next    = '0;
                    probes_next = (probes_cfg_reg > 5'(MAX_PROBES)) ?
                                  PW'(MAX_PROBES) : PW'(probes_cfg_reg);
                    bsize_next  = (bbytes_cfg_reg == 7'd0) ? 7'd1 :
                                  (bbytes_cfg_reg > 7'd64) ? 7'd64 : bbytes_cfg_reg;
                    blocks_next = (blocks_cfg_reg == 14'd0) ? 14'd1 : blocks_cfg_reg;
                    if (s_action == ACT_CLEAR) begin
                        clr_reply_next = 1'b1;
                        clr_cnt_next   = '0;
                        state_next     = ST_CLR;
                    end else if (s_action == ACT_INSERT || s_action == ACT_LOOKUP) begin
                        state_next = ST_HASH;
                    end else begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CLR: begin
                mem_addr     = clr_cnt_reg;
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(MEM_BYTES - 1)) begin
                    clr_cnt_next = '0;
                    res_next     = 1'b1;
                    state_next   = clr_reply_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_HASH: begin
                hstep_next = hstep_reg + 1'b1;
                case (hstep_reg)
                    4'd0: begin
                        mul_a = key_reg[31:0]; mul_b = MM_C1; t_next = mul_p;
                    end
                    4'd1, 4'd4: begin
                        mul_a = rotl(t_reg, 15); mul_b = MM_C2; t_next = mul_p;
                    end
                    4'd2, 4'd5: begin
                        mul_a = rotl(h_reg ^ t_reg, 13); mul_b = MM_FIVE; t_next = mul_p;
                    end
                    4'd3: begin
                        h_next = t_reg + MM_ADD;
                        mul_a  = key_reg[63:32]; mul_b = MM_C1; t_next = mul_p;
                    end
                    4'd6: h_next = (t_reg + MM_ADD) ^ MM_LEN;
                    4'd7: begin
                        mul_a = h_reg ^ (h_reg >> 16); mul_b = MM_F1; t_next = mul_p;
                    end
                    4'd8: begin
                        mul_a = t_reg ^ (t_reg >> 13); mul_b = MM_F2; t_next = mul_p;
                    end
                    default: begin
                        h_next           = t_reg ^ (t_reg >> 16);
                        div_req.start    = 1'b1;
                        div_req.dividend = t_reg ^ (t_reg >> 16);
                        div_req.divisor  = 32'(blocks_reg);
                        state_next       = ST_BDIV;
                    end
                endcase
            end
            ST_BDIV: begin
                if (div_rsp.done) state_next = ST_BASE;
            end
            ST_BASE: begin
                // block index times block size
                mul_a      = div_rsp.rem;
                mul_b      = 32'(bsize_reg);
                t_next     = mul_p;
                state_next = ST_MST;
            end
            ST_MST: begin
                // quotient by MEM_BYTES through the reciprocal
                mul_a      = t_reg;
                mul_b      = MEM_RECIP;
                q_next     = mul_full[63:32];
                state_next = ST_MDIV;
            end
            ST_MDIV: begin
                mul_a      = q_reg;
                mul_b      = MEM_W;
                base_next  = AW'((wrap_diff >= MEM_W) ? wrap_diff - MEM_W : wrap_diff);
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (idx_reg == probes_reg) begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = probe_val;
                    div_req.divisor  = 32'({bsize_reg, 3'b000});
                    state_next       = ST_PDIV;
                end
            end
            ST_PDIV: begin
                if (div_rsp.done) begin
                    // base below MEM_BYTES, offset below 64: one wrap at most
                    addr_next  = AW'((addr_sum >= MEM_SZ) ? addr_sum - MEM_SZ : addr_sum);
                    bit_next   = div_rsp.rem[2:0];
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (is_ins_reg) begin
                    mem_we     = 1'b1;
                    mem_wd     = rd_data_reg | bit_mask;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_PROBE;
                end else if ((rd_data_reg & bit_mask) == 8'd0) begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_present_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probes_cfg_reg <= 5'd7;
            bbytes_cfg_reg <= 7'd64;
            blocks_cfg_reg <= 14'd128;
            state_reg      <= ST_CLR;
            hstep_reg      <= '0;
            clr_cnt_reg    <= '0;
            clr_reply_reg  <= 1'b0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            probes_cfg_reg <= probes_cfg_next;
            bbytes_cfg_reg <= bbytes_cfg_next;
            blocks_cfg_reg <= blocks_cfg_next;
            state_reg      <= state_next;
            hstep_reg      <= hstep_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_reply_reg  <= clr_reply_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
        is_ins_reg    <= is_ins_next;
        key_reg       <= key_next;
        h_reg         <= h_next;
        t_reg         <= t_next;
        q_reg         <= q_next;
        probes_reg    <= probes_next;
        bsize_reg     <= bsize_next;
        blocks_reg    <= blocks_next;
        base_reg      <= base_next;
        addr_reg      <= addr_next;
        bit_reg       <= bit_next;
        res_reg       <= res_next;
        m_present_reg <= m_present_next;
    end

    // single-port byte memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        rd_data_reg <= mem[mem_addr];
    end

    `BBF_ASSERT_NOW(a_no_req_in_clear, aclk, aresetn, state_reg == ST_CLR, !s_ready)
    `BBF_ASSERT_NOW(a_idx_bound, aclk, aresetn, state_reg == ST_PROBE, idx_reg <= probes_reg)
    `BBF_ASSERT_NOW(a_div_done_waited, aclk, aresetn, div_rsp.done, div_wait)
    `BBF_ASSERT_NEXT(a_done_to_out, aclk, aresetn, out_take, m_valid && state_reg == ST_IDLE)

endmodule
`default_nettype wire
